### design/rle_pkg.sv
package rle_pkg;

   localparam int MAX_LITERAL_DEF = 32;
   localparam int COUNT_W         = 32;
   localparam int LEN_W           = 31;
   localparam logic [LEN_W-1:0] REPEAT_MAX = {LEN_W{1'b1}};

   typedef enum logic [1:0] {
      KIND_REPEAT   = 2'd0,
      KIND_LIT_HEAD = 2'd1,
      KIND_LIT_DATA = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                   record_kind;
      logic signed [COUNT_W-1:0]  run_count;
      logic [7:0]                 out_byte;
   } rec_type;

endpackage

### design/rle_req_if.sv
interface rle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

### design/rle_rsp_if.sv
interface rle_rsp_if;
   logic                valid;
   logic                ready;
   logic [1:0]          record_kind;
   logic signed [31:0]  run_count;
   logic [7:0]          out_byte;
   logic                group_last;
   logic                stream_end;

   modport source (output valid, output record_kind, output run_count, output out_byte,
                   output group_last, output stream_end, input ready);
   modport sink   (input valid, input record_kind, input run_count, input out_byte,
                   input group_last, input stream_end, output ready);
endinterface

### design/rle_literal_repeat_encoder.sv
// Sequence: after the accepting edge a word passes through step, then saturate (or close
//   plus update) when a run is open, finish, close and flush check on a final word, and
//   done, with literal header and literal data states per literal word; repeat words are emitted by saturate or close.
//   Its last output word is on rsp the cycle after done while rsp stays ready.
// Flow: a new input word is taken only after the last one reaches done; req is ready
//   only in idle. Reset: synchronous, active high; clears the sequencer, run state and
//   output valid flags. The literal memory is not cleared; only entries below the fill are read.
module rle_literal_repeat_encoder #(
   parameter int MAX_LITERAL = rle_pkg::MAX_LITERAL_DEF
) (
   input logic   clock,
   input logic   reset,
   rle_req_if.sink   req_chan,
   rle_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(MAX_LITERAL);
   localparam int FW = $clog2(MAX_LITERAL + 1);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_STEP   = 10'b00_0000_0010,
      ST_HEAD   = 10'b00_0000_0100,
      ST_DATA   = 10'b00_0000_1000,
      ST_SAT    = 10'b00_0001_0000,
      ST_CLOSE  = 10'b00_0010_0000,
      ST_UPD    = 10'b00_0100_0000,
      ST_FIN    = 10'b00_1000_0000,
      ST_FLUSHF = 10'b01_0000_0000,
      ST_DONE   = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      rle_pkg::rec_type rec;
      logic             group_last;
      logic             stream_end;
   } out_rec_type;

   state_type                   state_ff, state_in;
   state_type                   ret_ff, ret_in;
   logic [7:0]                  prev_ff, prev_in;
   logic                        have_ff, have_in;
   logic [rle_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [FW-1:0]               fill_ff, fill_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic [7:0]                  b_ff, b_in;
   logic                        fin_ff, fin_in;
   logic                        hold_valid_ff, hold_valid_in;
   rle_pkg::rec_type            hold_rec_ff, hold_rec_in;
   logic                        out_valid_ff, out_valid_in;
   out_rec_type                 out_rec_ff, out_rec_in;

   logic                        emit_req;
   rle_pkg::rec_type            emit_rec;
   logic                        out_free;
   logic                        hold_move;
   logic                        can_emit;
   logic                        emit_go;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [7:0]                  rd_data;
   logic [FW-1:0]               fill_inc;

   rle_lit_buf #(
      .MAX_LITERAL (MAX_LITERAL)
   ) u_lit_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (prev_ff),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   assign fill_inc = fill_ff + FW'(1);
   assign wr_addr  = fill_ff[AW-1:0];

   // record the current state wants to produce
   always_comb begin
      emit_req = 1'b0;
      emit_rec = '0;
      case (state_ff)
         ST_HEAD: begin
            emit_req             = 1'b1;
            emit_rec.record_kind = rle_pkg::KIND_LIT_HEAD;
            emit_rec.run_count   = $signed(32'd0 - 32'(fill_ff));
         end
         ST_DATA: begin
            emit_req             = 1'b1;
            emit_rec.record_kind = rle_pkg::KIND_LIT_DATA;
            emit_rec.out_byte    = rd_data;
         end
         ST_SAT, ST_CLOSE: begin
            emit_req             = (state_ff == ST_SAT) ? (len_ff == rle_pkg::REPEAT_MAX)
                                                        : (len_ff > rle_pkg::LEN_W'(1));
            emit_rec.record_kind = rle_pkg::KIND_REPEAT;
            emit_rec.run_count   = $signed({1'b0, len_ff});
            emit_rec.out_byte    = prev_ff;
         end
         default: begin
            emit_req = 1'b0;
         end
      endcase
   end

   // hold stage keeps one record until it is known whether it ends the word
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign hold_move = hold_valid_ff && out_free && (emit_req || state_ff == ST_DONE);
   assign can_emit  = !hold_valid_ff || hold_move;
   assign emit_go   = emit_req && can_emit;

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      prev_in       = prev_ff;
      have_in       = have_ff;
      len_in        = len_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      b_in          = b_ff;
      fin_in        = fin_ff;
      hold_valid_in = hold_valid_ff;
      hold_rec_in   = hold_rec_ff;
      out_valid_in  = out_valid_ff;
      out_rec_in    = out_rec_ff;
      wr_en         = 1'b0;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (hold_move) begin
         out_valid_in          = 1'b1;
         out_rec_in.rec        = hold_rec_ff;
         out_rec_in.group_last = (state_ff == ST_DONE);
         out_rec_in.stream_end = (state_ff == ST_DONE) && fin_ff;
         hold_valid_in         = 1'b0;
      end
      if (emit_go) begin
         hold_valid_in = 1'b1;
         hold_rec_in   = emit_rec;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               b_in     = req_chan.data_byte;
               fin_in   = req_chan.final_byte;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (!have_ff) begin
               prev_in  = b_ff;
               len_in   = rle_pkg::LEN_W'(1);
               have_in  = 1'b1;
               state_in = ST_FIN;
            end else if (b_ff == prev_ff) begin
               ret_in   = ST_SAT;
               state_in = (fill_ff != '0) ? ST_HEAD : ST_SAT;
            end else begin
               ret_in   = ST_UPD;
               state_in = ST_CLOSE;
            end
         end
         ST_HEAD: begin
            if (emit_go) begin
               idx_in   = '0;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (emit_go) begin
               if (FW'(idx_ff) + FW'(1) == fill_ff) begin
                  idx_in   = '0;
                  fill_in  = '0;
                  state_in = ret_ff;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         ST_SAT: begin
            if (emit_req) begin
               if (emit_go) begin
                  len_in   = rle_pkg::LEN_W'(1);
                  state_in = ST_FIN;
               end
            end else begin
               len_in   = len_ff + rle_pkg::LEN_W'(1);
               state_in = ST_FIN;
            end
         end
         ST_CLOSE: begin
            if (emit_req) begin
               if (emit_go) begin
                  state_in = ret_ff;
               end
            end else begin
               // single byte joins the literal buffer, flush when it fills
               wr_en    = 1'b1;
               fill_in  = fill_inc;
               state_in = (fill_inc == FW'(MAX_LITERAL)) ? ST_HEAD : ret_ff;
            end
         end
         ST_UPD: begin
            prev_in  = b_ff;
            len_in   = rle_pkg::LEN_W'(1);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (fin_ff) begin
               ret_in   = ST_FLUSHF;
               state_in = ST_CLOSE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FLUSHF: begin
            ret_in   = ST_DONE;
            state_in = (fill_ff != '0) ? ST_HEAD : ST_DONE;
         end
         ST_DONE: begin
            if (!hold_valid_ff || hold_move) begin
               if (fin_ff) begin
                  prev_in = '0;
                  have_in = 1'b0;
                  len_in  = rle_pkg::LEN_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_ff        <= ST_DONE;
         prev_ff       <= '0;
         have_ff       <= 1'b0;
         len_ff        <= rle_pkg::LEN_W'(1);
         fill_ff       <= '0;
         idx_ff        <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         prev_ff       <= prev_in;
         have_ff       <= have_in;
         len_ff        <= len_in;
         fill_ff       <= fill_in;
         idx_ff        <= idx_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      b_ff        <= b_in;
      fin_ff      <= fin_in;
      hold_rec_ff <= hold_rec_in;
      out_rec_ff  <= out_rec_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.record_kind = out_rec_ff.rec.record_kind;
   assign rsp_chan.run_count   = out_rec_ff.rec.run_count;
   assign rsp_chan.out_byte    = out_rec_ff.rec.out_byte;
   assign rsp_chan.group_last  = out_rec_ff.group_last;
   assign rsp_chan.stream_end  = out_rec_ff.stream_end;

`ifndef SYNTHESIS
   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hold_valid_ff)
      else $error("record left in hold stage at idle");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(MAX_LITERAL))
      else $error("literal fill beyond buffer size");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_rec_ff.stream_end |-> out_rec_ff.group_last)
      else $error("stream end without group last");

   a_msg_end_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && fin_ff && state_in == ST_IDLE |=> !have_ff && fill_ff == '0)
      else $error("run state not cleared after message end");
`endif

endmodule

### design/rle_lit_buf.sv
module rle_lit_buf #(
   parameter int MAX_LITERAL = rle_pkg::MAX_LITERAL_DEF,
   localparam int AW = $clog2(MAX_LITERAL)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] store_ff [MAX_LITERAL];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
